### hdl/sshd_pkg.sv
// Shared types and constants for the SSH packet deframer.
package sshd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 32;
  localparam int unsigned HdrBytes = 5;
  localparam int unsigned MinPad   = 4;
  localparam int unsigned OutDataW = 48;

  localparam logic [LenW-1:0] MaxLenReset      = 32'd35000;
  localparam int unsigned     FifoDepthDefault = 4;

  typedef enum logic [2:0] {
    StOk     = 3'd0,
    StShort  = 3'd1,
    StTrunc  = 3'd2,
    StZero   = 3'd3,
    StPadLow = 3'd4,
    StPadBig = 3'd5,
    StOver   = 3'd6
  } status_e;

  // One result item as it sits in the output queue.
  typedef struct packed {
    logic [LenW-1:0]  plen;
    status_e          status;
    logic             last;
    logic [ByteW-1:0] pbyte;
  } result_t;

  // Results produced by one accepted byte: a payload result, a status result, or both.
  typedef struct packed {
    logic    fwd;
    logic    stat;
    result_t fwd_res;
    result_t stat_res;
  } push_req_t;

endpackage

### hdl/ssh_packet_deframer.sv
// SSH binary packet deframer: splits one raw packet into payload bytes and a status result.
//
// Input stream: one raw packet byte per transfer in s_axis_tdata, s_axis_tlast on the final
// byte. Bytes 0..3 are the big-endian packet length, byte 4 the padding length; the payload
// bytes that follow are forwarded on the output stream, padding and trailing bytes are dropped.
// Output stream: a payload result per forwarded byte (tlast low), then on the final input byte
// one status result (tlast high) carrying the status code and, when ok, the payload length.
// A nonzero status tells the consumer to discard the payload it already took.
// Configuration: cfg_we_i writes cfg_wdata_i into max_packet_length (reset 35000); a larger
// length field yields status oversize.
// Throughput: one input byte per cycle while the result queue has room; results leave the block
// one per cycle while m_axis_tready is high. Results are registered in the queue before they are offered.
// The per-byte work is the 32-bit status compares plus a down counter of payload bytes left, all
// between the packet state registers and a small result queue (FifoDepth entries).
// Stall: when the output stalls the queue fills and s_axis_tready drops once fewer than two
// free entries remain; nothing is lost or repeated.
// Reset: clears the packet state and empties the queue; max_packet_length returns to 35000.
module ssh_packet_deframer
  import sshd_pkg::*;
#(
  parameter int unsigned FifoDepth = FifoDepthDefault  // at least 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [LenW-1:0]     cfg_wdata_i,    // max_packet_length
  // raw byte stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,   // [7:0] raw_byte
  input  logic                s_axis_tlast,   // last_byte
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status,
                                              // [42:11] payload_length, [47:43] zero
  output logic                m_axis_tlast    // end_flag
);

  logic [LenW-1:0]  max_len_q;
  logic [LenW-1:0]  count_q, count_d;     // bytes received in this packet, saturating
  logic [LenW-1:0]  length_q, length_d;   // packet length field
  logic [ByteW-1:0] pad_q, pad_d;         // padding length
  logic             hdr_ok_q, hdr_ok_d;   // padding >= 4 and length > padding
  logic [LenW-1:0]  rem_q, rem_d;         // payload positions still ahead
  logic [LenW-1:0]  plen_q, plen_d;       // payload length from the header

  logic             in_acc;
  logic             pos_lt4, pos_eq4, pos_ge5;
  logic             adv;
  logic             fwd;
  logic [ByteW-1:0] pad_cur;
  status_e          status;
  logic [LenW-1:0]  plen_out;
  push_req_t        push;
  result_t          out_res;
  logic             space;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign pos_lt4 = (count_q < LenW'(HdrBytes - 1));
  assign pos_eq4 = (count_q == LenW'(HdrBytes - 1));
  assign pos_ge5 = (count_q > LenW'(HdrBytes - 1));

  // Step through the payload positions whether or not the byte goes out.
  assign adv = in_acc & pos_ge5 & (rem_q != '0);

  // Forward a payload byte while the header checks pass, the length is within max_packet_length and bytes remain.
  assign fwd = adv & hdr_ok_q & (length_q <= max_len_q);

  // Padding byte arriving now counts for the checks of this very byte.
  assign pad_cur = pos_eq4 ? s_axis_tdata : pad_q;

  // Status checks in order of precedence.
  always_comb begin
    status   = StOk;
    plen_out = '0;
    if (pos_lt4) begin
      status = StShort;
    end else if (({1'b0, length_q} + (LenW + 1)'(3)) > {1'b0, count_q}) begin
      status = StTrunc;
    end else if (length_q == '0) begin
      status = StZero;
    end else if (pad_cur < ByteW'(MinPad)) begin
      status = StPadLow;
    end else if (LenW'(pad_cur) >= length_q) begin
      status = StPadBig;
    end else if (length_q > max_len_q) begin
      status = StOver;
    end else begin
      plen_out = plen_q;
    end
  end

  // Packet state update; the final byte returns everything to the start of a packet.
  always_comb begin
    count_d  = count_q;
    length_d = length_q;
    pad_d    = pad_q;
    hdr_ok_d = hdr_ok_q;
    rem_d    = rem_q;
    plen_d   = plen_q;
    if (in_acc) begin
      if (s_axis_tlast) begin
        count_d  = '0;
        length_d = '0;
        pad_d    = '0;
        hdr_ok_d = 1'b0;
        rem_d    = '0;
      end else begin
        if (count_q != '1) begin
          count_d = count_q + 1'b1;
        end
        if (pos_lt4) begin
          length_d = {length_q[LenW-ByteW-1:0], s_axis_tdata};
        end
        if (pos_eq4) begin
          pad_d    = s_axis_tdata;
          hdr_ok_d = (s_axis_tdata >= ByteW'(MinPad)) & (length_q > LenW'(s_axis_tdata));
          plen_d   = length_q - LenW'(1) - LenW'(s_axis_tdata);
          rem_d    = length_q - LenW'(1) - LenW'(s_axis_tdata);
        end
        if (adv) begin
          rem_d = rem_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
      count_q   <= '0;
      length_q  <= '0;
      pad_q     <= '0;
      hdr_ok_q  <= 1'b0;
      rem_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      count_q  <= count_d;
      length_q <= length_d;
      pad_q    <= pad_d;
      hdr_ok_q <= hdr_ok_d;
      rem_q    <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plen_q <= plen_d;
  end

  // Payload result first, status result behind it.
  always_comb begin
    push.fwd              = fwd;
    push.fwd_res.plen     = '0;
    push.fwd_res.status   = StOk;
    push.fwd_res.last     = 1'b0;
    push.fwd_res.pbyte    = s_axis_tdata;
    push.stat             = in_acc & s_axis_tlast;
    push.stat_res.plen    = plen_out;
    push.stat_res.status  = status;
    push.stat_res.last    = 1'b1;
    push.stat_res.pbyte   = '0;
  end

  sshd_res_fifo #(
    .Depth (FifoDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign s_axis_tready = space;
  assign m_axis_tdata  = {(OutDataW - LenW - 3 - ByteW)'(0), out_res.plen, out_res.status,
                          out_res.pbyte};
  assign m_axis_tlast  = out_res.last;

  a_clear_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (count_q == '0 && !hdr_ok_q && rem_q == '0))
    else $error("packet state not cleared after final byte");

  a_hdr_after_header : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_ok_q |-> pos_ge5)
    else $error("header checks valid before header complete");

  a_valid_from_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_acc))
    else $error("result appeared without an accepted byte");

endmodule

### hdl/sshd_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while ready_i is high.
module sshd_res_fifo
  import sshd_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_req_t push_i,
  output logic      space_o,
  output logic      valid_o,
  input  logic      ready_i,
  output result_t   res_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t         slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nxt, wr_sel;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [1:0]      push_n;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign pop        = valid_o & ready_i;
  assign push_n     = {1'b0, push_i.fwd} + {1'b0, push_i.stat};
  assign wr_ptr_nxt = ptr_inc(wr_ptr_q);
  assign wr_sel     = push_i.fwd ? wr_ptr_nxt : wr_ptr_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_n == 2'd2) begin
      wr_ptr_d = ptr_inc(wr_ptr_nxt);
    end else if (push_n == 2'd1) begin
      wr_ptr_d = wr_ptr_nxt;
    end
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_n) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.fwd) begin
      slot_q[wr_ptr_q] <= push_i.fwd_res;
    end
    if (push_i.stat) begin
      slot_q[wr_sel] <= push_i.stat_res;
    end
  end

  assign res_o   = slot_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign space_o = (cnt_q <= CntW'(Depth - 2));

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overfilled");

  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("empty queue with mismatched pointers");

endmodule
